>>> rtl/core/rpfa_pkg.sv
// Shared types, constants and fixed-point helpers for the radial pair force accumulator.
`timescale 1ns / 1ps

package rpfa_pkg;

  localparam int unsigned ATOMS_DEF     = 1024;
  localparam int unsigned MAX_TERMS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned CHANNELS      = 3;
  localparam int unsigned TERM_COUNT_RST = 16;

  // Input item kinds (tuser)
  localparam logic [1:0] KIND_COEF = 2'd0;
  localparam logic [1:0] KIND_GRAD = 2'd1;
  localparam logic [1:0] KIND_PAIR = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  // Channels
  localparam logic [1:0] CH_SAME_MOL = 2'd0;
  localparam logic [1:0] CH_OTHER    = 2'd1;
  localparam logic [1:0] CH_PARTNER  = 2'd2;

  // Exponential constants
  localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
  localparam logic [31:0]        INV_LN2     = 32'd94548;   // 2^32 / (2^16 * ln2), rounded down
  localparam logic signed [31:0] EXP_HI      = 32'sd720896;   // 11.0
  localparam logic signed [31:0] EXP_LO      = -32'sd786432;  // -12.0
  localparam logic signed [31:0] Q_ONE       = 32'sd65536;
  localparam logic signed [31:0] Q_HALF      = 32'sd32768;
  localparam logic [3:0]         TAYLOR_LAST = 4'd12;
  localparam logic [3:0]         TAYLOR_FIRST = 4'd2;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_COEF  = 3'd1,
    OP_GRAD  = 3'd2,
    OP_PAIR  = 3'd3,
    OP_READ  = 3'd4,
    OP_RZERO = 3'd5
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [9:0]         atom;
    logic [9:0]         nb;
    logic [1:0]         ch;
    logic               same;
    logic signed [31:0] sv;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic [5:0]         tix;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } bk_status_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -33'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Q16.16 product: add half, floor shift by 16, saturate
  function automatic logic signed [31:0] qround(input logic signed [65:0] p);
    logic signed [65:0] t;
    logic signed [49:0] s;
    logic signed [31:0] r;
    t = p + 66'sd32768;
    s = $signed(t[65:16]);
    if (s > 50'sd2147483647) r = 32'sh7FFFFFFF;
    else if (s < -50'sd2147483648) r = 32'sh80000000;
    else r = s[31:0];
    return r;
  endfunction

  // floor(2^32 / n) for the Taylor divisors
  function automatic logic [31:0] recip(input logic [3:0] n);
    logic [31:0] r;
    case (n)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      default: r = 32'hFFFFFFFF;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/radial_pair_force_accumulator_core.sv
// Top level of the radial pair force accumulator: front end, item queue, back end.
// Sequence: loads are written while the back end is idle; a read goes through ST_RRD,
//   ST_RCAP and ST_ROUT, which waits for a free output register, before its force is out.
// Throughput: one pair at a time, bounded by the shared multiplier stepping each term
//   (exponential series up to r^12/12!, then dependent products ST_M1-ST_M4, ST_G per axis).
// Reset: asynchronous, active low; afterwards the force store is zeroed one atom row
//   per cycle, rows 0 to ATOMS-1, with s_axis_tready low. term_count resets to 16.
`timescale 1ns / 1ps

module radial_pair_force_accumulator_core #(
  parameter int unsigned ATOMS     = rpfa_pkg::ATOMS_DEF,
  parameter int unsigned MAX_TERMS = rpfa_pkg::MAX_TERMS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // term_count register
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,
  // input transactions
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, low bit up: atom[9:0], neighbor_atom[19:10], atom_molecule[29:20],
  // neighbor_molecule[39:30], partner_color[47:40], neighbor_color[55:48],
  // scalar_value[87:56], deriv_x[119:88], deriv_y[151:120], deriv_z[183:152],
  // table_index[189:184], zero pad[191:190]
  input  logic [191:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,   // kind[1:0]
  // result transactions
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, low bit up: out_atom[9:0], force_x[41:10], force_y[73:42], force_z[105:74],
  // zero pad[111:106]
  output logic [111:0] m_axis_tdata
);

  logic [4:0]           term_count_q;
  rpfa_pkg::bk_status_t st;
  rpfa_pkg::item_t      push_item, pop_item;
  logic                 push_valid, push_ready, pop_valid, pop_ready;
  logic [9:0]           out_atom;
  logic signed [31:0]   fx, fy, fz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= 5'(rpfa_pkg::TERM_COUNT_RST);
    end else if (cfg_we_i) begin
      term_count_q <= cfg_wdata_i;
    end
  end

  // classify and range check
  rpfa_front #(.ATOMS(ATOMS), .MAX_TERMS(MAX_TERMS)) u_front (
    .tvalid_i     (s_axis_tvalid),
    .tready_o     (s_axis_tready),
    .tdata_i      (s_axis_tdata),
    .tuser_i      (s_axis_tuser),
    .status_i     (st),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // decouples acceptance from the long pair sequence
  rpfa_queue #(.DEPTH(rpfa_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // stores, exponential and force accumulation
  rpfa_back #(.ATOMS(ATOMS), .MAX_TERMS(MAX_TERMS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_count_i (term_count_q),
    .q_valid_i    (pop_valid),
    .q_ready_o    (pop_ready),
    .q_item_i     (pop_item),
    .status_o     (st),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_atom_o   (out_atom),
    .force_x_o    (fx),
    .force_y_o    (fy),
    .force_z_o    (fz)
  );

  assign m_axis_tdata = {6'd0, fz, fy, fx, out_atom};

  // no transaction taken while the force store is being zeroed
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.clearing |-> !s_axis_tready)
    else $error("input accepted during force store clear");

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.clearing |-> !m_axis_tvalid)
    else $error("result valid during force store clear");

  // a queued item must stay queued until the back end takes it
  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && !pop_ready |=> pop_valid)
    else $error("queued item lost before back end took it");

endmodule

>>> rtl/core/rpfa_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module rpfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rpfa_front.sv
// Front end: unpacks input transactions, range-checks them and picks the pair channel.
`timescale 1ns / 1ps

module rpfa_front #(
  parameter int unsigned ATOMS     = rpfa_pkg::ATOMS_DEF,
  parameter int unsigned MAX_TERMS = rpfa_pkg::MAX_TERMS_DEF
) (
  input  logic                    tvalid_i,
  output logic                    tready_o,
  input  logic [191:0]            tdata_i,
  input  logic [1:0]              tuser_i,
  input  rpfa_pkg::bk_status_t    status_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output rpfa_pkg::item_t         push_item_o
);

  logic [9:0] atom, nb, mol_a, mol_n;
  logic [7:0] pcol, ncol;
  logic [5:0] tix;
  logic       atom_ok, nb_ok;

  assign atom  = tdata_i[9:0];
  assign nb    = tdata_i[19:10];
  assign mol_a = tdata_i[29:20];
  assign mol_n = tdata_i[39:30];
  assign pcol  = tdata_i[47:40];
  assign ncol  = tdata_i[55:48];
  assign tix   = tdata_i[189:184];

  assign atom_ok = (int'(atom) < ATOMS);
  assign nb_ok   = (int'(nb) < ATOMS);

  always_comb begin
    push_item_o.atom = atom;
    push_item_o.nb   = nb;
    push_item_o.sv   = $signed(tdata_i[87:56]);
    push_item_o.dx   = $signed(tdata_i[119:88]);
    push_item_o.dy   = $signed(tdata_i[151:120]);
    push_item_o.dz   = $signed(tdata_i[183:152]);
    push_item_o.tix  = tix;
    push_item_o.same = (atom == nb);
    if (mol_a == mol_n) push_item_o.ch = rpfa_pkg::CH_SAME_MOL;
    else if (pcol == ncol) push_item_o.ch = rpfa_pkg::CH_PARTNER;
    else push_item_o.ch = rpfa_pkg::CH_OTHER;

    push_item_o.op = rpfa_pkg::OP_NOP;
    case (tuser_i)
      rpfa_pkg::KIND_COEF: begin
        if (int'(tix) < rpfa_pkg::CHANNELS * MAX_TERMS) push_item_o.op = rpfa_pkg::OP_COEF;
      end
      rpfa_pkg::KIND_GRAD: begin
        if (atom_ok && int'(tix) < MAX_TERMS) push_item_o.op = rpfa_pkg::OP_GRAD;
      end
      rpfa_pkg::KIND_PAIR: begin
        if (atom_ok && nb_ok) push_item_o.op = rpfa_pkg::OP_PAIR;
      end
      rpfa_pkg::KIND_READ: begin
        push_item_o.op = atom_ok ? rpfa_pkg::OP_READ : rpfa_pkg::OP_RZERO;
      end
      default: push_item_o.op = rpfa_pkg::OP_NOP;
    endcase
  end

  assign tready_o     = push_ready_i && !status_i.clearing;
  assign push_valid_o = tvalid_i && !status_i.clearing;

endmodule

>>> rtl/core/rpfa_queue.sv
// Small FIFO between the front end and the back end.
`timescale 1ns / 1ps

module rpfa_queue #(
  parameter int unsigned DEPTH = rpfa_pkg::QUEUE_DEPTH,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  rpfa_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output rpfa_pkg::item_t pop_item_o
);

  rpfa_pkg::item_t ent_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = ent_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> rtl/core/rpfa_back.sv
// Back end: table and force stores, per-term sequencer with one shared multiplier.
`timescale 1ns / 1ps

module rpfa_back #(
  parameter int unsigned ATOMS     = rpfa_pkg::ATOMS_DEF,
  parameter int unsigned MAX_TERMS = rpfa_pkg::MAX_TERMS_DEF,
  localparam int unsigned COEF_D = rpfa_pkg::CHANNELS * MAX_TERMS,
  localparam int unsigned CAW = $clog2(COEF_D),
  localparam int unsigned GAW = $clog2(ATOMS * MAX_TERMS),
  localparam int unsigned FAW = $clog2(ATOMS),
  localparam int unsigned TCW = $clog2(MAX_TERMS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [4:0]           term_count_i,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  rpfa_pkg::item_t      q_item_i,
  output rpfa_pkg::bk_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [9:0]           out_atom_o,
  output logic signed [31:0]   force_x_o,
  output logic signed [31:0]   force_y_o,
  output logic signed [31:0]   force_z_o
);

  typedef enum logic [24:0] {
    ST_CLEAR = 25'd1 << 0,
    ST_IDLE  = 25'd1 << 1,
    ST_RDC   = 25'd1 << 2,
    ST_RDN   = 25'd1 << 3,
    ST_CAPN  = 25'd1 << 4,
    ST_COEF  = 25'd1 << 5,
    ST_AD    = 25'd1 << 6,
    ST_EK    = 25'd1 << 7,
    ST_ER    = 25'd1 << 8,
    ST_EC    = 25'd1 << 9,
    ST_T1    = 25'd1 << 10,
    ST_T2    = 25'd1 << 11,
    ST_T3    = 25'd1 << 12,
    ST_ES    = 25'd1 << 13,
    ST_M1    = 25'd1 << 14,
    ST_M2    = 25'd1 << 15,
    ST_M3    = 25'd1 << 16,
    ST_M4    = 25'd1 << 17,
    ST_G     = 25'd1 << 18,
    ST_A     = 25'd1 << 19,
    ST_WRC   = 25'd1 << 20,
    ST_WRN   = 25'd1 << 21,
    ST_RRD   = 25'd1 << 22,
    ST_RCAP  = 25'd1 << 23,
    ST_ROUT  = 25'd1 << 24
  } state_e;

  state_e             state_q;
  rpfa_pkg::item_t    cur_q;
  logic [TCW-1:0]     nt_q, i_q, nt_in;
  logic [1:0]         ax_q;
  logic signed [31:0] c_q [3];
  logic signed [31:0] n_q [3];
  logic signed [31:0] w_q, grad_q, ad_q, e_q, t1_q, s_q, h_q, gs_q, g_q;
  logic [5:0]         kest_q, k_q;
  logic signed [49:0] rraw_q;
  logic [31:0]        r_q, term_q, v_q, qe_q;
  logic [33:0]        sum_q;
  logic [3:0]         tn_q;
  logic [FAW-1:0]     clr_q;
  logic [95:0]        res_q;
  logic               out_vld_q;
  logic [9:0]         out_atom_q;
  logic [95:0]        out_f_q;

  // RAM ports
  logic               c_we, c_re, g_we, g_re, f_we, f_re;
  logic [CAW-1:0]     c_addr;
  logic [GAW-1:0]     g_addr;
  logic [FAW-1:0]     f_addr;
  logic [63:0]        c_wdata, c_rdata;
  logic [31:0]        g_rdata;
  logic [95:0]        f_wdata, f_rdata;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [31:0] qr;

  // misc combinational
  logic signed [49:0] xq;
  logic signed [32:0] rem;
  logic [31:0]        qfix;
  logic signed [6:0]  shs;
  logic [5:0]         sh;
  logic [34:0]        rnd, eres;
  logic signed [31:0] onep, dsel, negg, cnew, cfin, nfin;

  assign nt_in = (int'(term_count_i) > MAX_TERMS) ? TCW'(MAX_TERMS) : TCW'(term_count_i);

  rpfa_ram #(.WIDTH(64), .DEPTH(COEF_D)) u_coef (
    .clk_i(clk_i), .we_i(c_we), .re_i(c_re), .addr_i(c_addr), .wdata_i(c_wdata),
    .rdata_o(c_rdata)
  );
  rpfa_ram #(.WIDTH(32), .DEPTH(ATOMS * MAX_TERMS)) u_grad (
    .clk_i(clk_i), .we_i(g_we), .re_i(g_re), .addr_i(g_addr), .wdata_i(q_item_i.sv),
    .rdata_o(g_rdata)
  );
  rpfa_ram #(.WIDTH(96), .DEPTH(ATOMS)) u_force (
    .clk_i(clk_i), .we_i(f_we), .re_i(f_re), .addr_i(f_addr), .wdata_i(f_wdata),
    .rdata_o(f_rdata)
  );

  assign q_ready_o = (state_q == ST_IDLE);

  // table ports
  always_comb begin
    c_we    = 1'b0;
    c_re    = 1'b0;
    g_we    = 1'b0;
    g_re    = 1'b0;
    c_wdata = {q_item_i.dx, q_item_i.sv};
    c_addr  = CAW'(q_item_i.tix);
    g_addr  = GAW'(int'(q_item_i.atom) * MAX_TERMS + int'(q_item_i.tix));
    if (state_q == ST_IDLE) begin
      c_we = q_valid_i && (q_item_i.op == rpfa_pkg::OP_COEF);
      g_we = q_valid_i && (q_item_i.op == rpfa_pkg::OP_GRAD);
    end else if (state_q == ST_COEF) begin
      c_re   = 1'b1;
      g_re   = 1'b1;
      c_addr = CAW'(int'(cur_q.ch) * MAX_TERMS + int'(i_q));
      g_addr = GAW'(int'(cur_q.atom) * MAX_TERMS + int'(i_q));
    end
  end

  // force store port
  always_comb begin
    f_we    = 1'b0;
    f_re    = 1'b0;
    f_addr  = FAW'(cur_q.atom);
    f_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        f_we   = 1'b1;
        f_addr = clr_q;
      end
      ST_RDC:  f_re = 1'b1;
      ST_RDN: begin
        f_re   = 1'b1;
        f_addr = FAW'(cur_q.nb);
      end
      ST_WRC: begin
        f_we    = 1'b1;
        f_wdata = {c_q[2], c_q[1], c_q[0]};
      end
      ST_WRN: begin
        f_we    = 1'b1;
        f_addr  = FAW'(cur_q.nb);
        f_wdata = {n_q[2], n_q[1], n_q[0]};
      end
      ST_RRD:  f_re = 1'b1;
      ST_RCAP: f_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    case (ax_q)
      2'd0:    dsel = cur_q.dx;
      2'd1:    dsel = cur_q.dy;
      default: dsel = cur_q.dz;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_AD: begin
        mul_a = {c_rdata[31], c_rdata[31:0]};
        mul_b = {cur_q.sv[31], cur_q.sv};
      end
      ST_EK: begin
        mul_a = {ad_q[31], ad_q};
        mul_b = {1'b0, rpfa_pkg::INV_LN2};
      end
      ST_ER: begin
        mul_a = {{27{kest_q[5]}}, kest_q};
        mul_b = {1'b0, rpfa_pkg::LN2_Q32};
      end
      ST_T1: begin
        mul_a = {1'b0, term_q};
        mul_b = {1'b0, r_q};
      end
      ST_T2: begin
        mul_a = {1'b0, v_q};
        mul_b = {1'b0, rpfa_pkg::recip(tn_q)};
      end
      ST_T3: begin
        mul_a = {1'b0, qe_q};
        mul_b = {29'd0, tn_q};
      end
      ST_M1: begin
        mul_a = {w_q[31], w_q};
        mul_b = {e_q[31], e_q};
      end
      ST_M2: begin
        mul_a = {t1_q[31], t1_q};
        mul_b = {onep[31], onep};
      end
      ST_M3: begin
        mul_a = {s_q[31], s_q};
        mul_b = {rpfa_pkg::Q_HALF[31], rpfa_pkg::Q_HALF};
      end
      ST_M4: begin
        mul_a = {h_q[31], h_q};
        mul_b = {grad_q[31], grad_q};
      end
      ST_G: begin
        mul_a = {gs_q[31], gs_q};
        mul_b = {dsel[31], dsel};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign qr    = rpfa_pkg::qround(mul_p);

  // exponent helpers
  assign xq   = $signed({{2{ad_q[31]}}, ad_q, 16'd0});
  assign rem  = $signed({1'b0, v_q}) - $signed(mul_p[32:0]);
  assign qfix = (rem >= $signed({29'd0, tn_q})) ? qe_q + 32'd1 : qe_q;
  assign shs  = 7'sd16 - $signed({k_q[5], k_q});
  assign sh   = shs[5:0];
  assign rnd  = 35'd1 << (sh - 6'd1);
  assign eres = ({1'b0, sum_q} + rnd) >> sh;
  assign onep = rpfa_pkg::sat33($signed({ad_q[31], ad_q}) + 33'sd65536);

  // force update for one axis: central first, then neighbor
  always_comb begin
    negg = rpfa_pkg::sat33(-$signed({g_q[31], g_q}));
    cnew = rpfa_pkg::sat33($signed({c_q[ax_q][31], c_q[ax_q]}) + $signed({negg[31], negg}));
    cfin = cur_q.same ? rpfa_pkg::sat33($signed({cnew[31], cnew}) + $signed({g_q[31], g_q}))
                      : cnew;
    nfin = rpfa_pkg::sat33($signed({n_q[ax_q][31], n_q[ax_q]}) + $signed({g_q[31], g_q}));
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE:  cur_q <= q_item_i;
      ST_RDN: begin
        c_q[0] <= f_rdata[31:0];
        c_q[1] <= f_rdata[63:32];
        c_q[2] <= f_rdata[95:64];
      end
      ST_CAPN: begin
        n_q[0] <= f_rdata[31:0];
        n_q[1] <= f_rdata[63:32];
        n_q[2] <= f_rdata[95:64];
      end
      ST_AD: begin
        ad_q   <= qr;
        w_q    <= c_rdata[63:32];
        grad_q <= g_rdata;
      end
      ST_EK: begin
        kest_q <= mul_p[37:32];
        if (ad_q > rpfa_pkg::EXP_HI) e_q <= 32'sh7FFFFFFF;
        else e_q <= '0;
      end
      ST_ER: rraw_q <= xq - mul_p[49:0];
      ST_EC: begin
        if (rraw_q < 0) begin
          k_q <= kest_q - 6'd1;
          r_q <= 32'(rraw_q + $signed({18'd0, rpfa_pkg::LN2_Q32}));
        end else if (rraw_q >= $signed({18'd0, rpfa_pkg::LN2_Q32})) begin
          k_q <= kest_q + 6'd1;
          r_q <= 32'(rraw_q - $signed({18'd0, rpfa_pkg::LN2_Q32}));
        end else begin
          k_q <= kest_q;
          r_q <= rraw_q[31:0];
        end
      end
      ST_T1: v_q  <= mul_p[63:32];
      ST_T2: qe_q <= mul_p[63:32];
      ST_ES: e_q  <= (eres > 35'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(eres[31:0]);
      ST_M1: t1_q <= qr;
      ST_M2: s_q  <= qr;
      ST_M3: h_q  <= qr;
      ST_M4: gs_q <= qr;
      ST_G:  g_q  <= qr;
      ST_A: begin
        c_q[ax_q] <= cfin;
        n_q[ax_q] <= nfin;
      end
      ST_RCAP: res_q <= f_rdata;
      default: ;
    endcase
    if (state_q == ST_IDLE && q_item_i.op == rpfa_pkg::OP_RZERO) res_q <= '0;
    if (state_q == ST_EC) begin
      // first Taylor term is r itself
      if (rraw_q < 0) begin
        term_q <= 32'(rraw_q + $signed({18'd0, rpfa_pkg::LN2_Q32}));
        sum_q  <= 34'h100000000 + 34'(rraw_q + $signed({18'd0, rpfa_pkg::LN2_Q32}));
      end else if (rraw_q >= $signed({18'd0, rpfa_pkg::LN2_Q32})) begin
        term_q <= 32'(rraw_q - $signed({18'd0, rpfa_pkg::LN2_Q32}));
        sum_q  <= 34'h100000000 + 34'(rraw_q - $signed({18'd0, rpfa_pkg::LN2_Q32}));
      end else begin
        term_q <= rraw_q[31:0];
        sum_q  <= 34'h100000000 + {2'd0, rraw_q[31:0]};
      end
    end
    if (state_q == ST_T3) begin
      term_q <= qfix;
      sum_q  <= sum_q + {2'd0, qfix};
    end
    if (state_q == ST_ROUT && (!out_vld_q || out_ready_i)) begin
      out_atom_q <= cur_q.atom;
      out_f_q    <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      nt_q      <= '0;
      i_q       <= '0;
      ax_q      <= '0;
      tn_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_ready_i) out_vld_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == FAW'(ATOMS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            case (q_item_i.op)
              rpfa_pkg::OP_PAIR: begin
                if (nt_in != '0) begin
                  nt_q    <= nt_in;
                  i_q     <= '0;
                  state_q <= ST_RDC;
                end
              end
              rpfa_pkg::OP_READ:  state_q <= ST_RRD;
              rpfa_pkg::OP_RZERO: state_q <= ST_ROUT;
              default: ;
            endcase
          end
        end
        ST_RDC:  state_q <= ST_RDN;
        ST_RDN:  state_q <= ST_CAPN;
        ST_CAPN: state_q <= ST_COEF;
        ST_COEF: state_q <= ST_AD;
        ST_AD:   state_q <= ST_EK;
        ST_EK: begin
          if (ad_q > rpfa_pkg::EXP_HI || ad_q < rpfa_pkg::EXP_LO) state_q <= ST_M1;
          else state_q <= ST_ER;
        end
        ST_ER: state_q <= ST_EC;
        ST_EC: begin
          tn_q    <= rpfa_pkg::TAYLOR_FIRST;
          state_q <= ST_T1;
        end
        ST_T1: state_q <= ST_T2;
        ST_T2: state_q <= ST_T3;
        ST_T3: begin
          if (tn_q == rpfa_pkg::TAYLOR_LAST) begin
            state_q <= ST_ES;
          end else begin
            tn_q    <= tn_q + 4'd1;
            state_q <= ST_T1;
          end
        end
        ST_ES: state_q <= ST_M1;
        ST_M1: state_q <= ST_M2;
        ST_M2: state_q <= ST_M3;
        ST_M3: state_q <= ST_M4;
        ST_M4: begin
          ax_q    <= '0;
          state_q <= ST_G;
        end
        ST_G: state_q <= ST_A;
        ST_A: begin
          if (ax_q == 2'd2) begin
            if (i_q + 1'b1 == nt_q) begin
              state_q <= ST_WRC;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_COEF;
            end
          end else begin
            ax_q    <= ax_q + 2'd1;
            state_q <= ST_G;
          end
        end
        ST_WRC:  state_q <= cur_q.same ? ST_IDLE : ST_WRN;
        ST_WRN:  state_q <= ST_IDLE;
        ST_RRD:  state_q <= ST_RCAP;
        ST_RCAP: state_q <= ST_ROUT;
        ST_ROUT: begin
          if (!out_vld_q || out_ready_i) begin
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign status_o.idle     = (state_q == ST_IDLE);

  assign out_valid_o = out_vld_q;
  assign out_atom_o  = out_atom_q;
  assign force_x_o   = out_f_q[31:0];
  assign force_y_o   = out_f_q[63:32];
  assign force_z_o   = out_f_q[95:64];

endmodule

>>> verif/tb_radial_pair_force_accumulator_core.sv
// Self-checking testbench for radial_pair_force_accumulator_core.
`timescale 1ns / 1ps

typedef longint unsigned u64_t;

typedef struct {
  logic [1:0]         kind;
  logic [9:0]         atom;
  logic [9:0]         nb;
  logic [9:0]         amol;
  logic [9:0]         nmol;
  logic [7:0]         pcol;
  logic [7:0]         ncol;
  logic signed [31:0] sv;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] dz;
  logic [5:0]         tix;
} accum_cmd_t;

typedef struct {
  logic [9:0]  atom;
  logic [31:0] fx;
  logic [31:0] fy;
  logic [31:0] fz;
} force_rd_t;

// Force predictor plus the queue of force reads still owed by the block
class force_scoreboard;
  int          alpha_tbl[48];
  int          weight_tbl[48];
  int          grad_tbl[16384];
  int          force_mem[3072];
  int unsigned term_cfg;
  force_rd_t   due_q[$];
  int          mismatches;

  function new();
    foreach (force_mem[i]) force_mem[i] = 0;
    term_cfg   = 16;
    mismatches = 0;
  endfunction

  function int sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // Q16.16 product, round half up, floor shift, saturate
  function int qmul(int a, int b);
    longint q;
    q = longint'(a) * longint'(b) + 32768;
    return sat(q >>> 16);
  endfunction

  function int qexp(int x);
    longint k;
    longint r;
    longint xq;
    u64_t   sum;
    u64_t   term;
    u64_t   res;
    int     shift;
    if (longint'(x) > 64'sd720896) return 32'sh7FFFFFFF;
    if (longint'(x) < -64'sd786432) return 0;
    xq = longint'(x) * 65536;
    k  = xq / 64'sd2977044472;
    r  = xq - k * 64'sd2977044472;
    if (r < 0) begin
      k--;
      r += 64'sd2977044472;
    end
    sum  = 64'h1_0000_0000;
    term = 64'h1_0000_0000;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * u64_t'(r)) >> 32) / u64_t'(n);
      sum += term;
    end
    shift = 16 - int'(k);
    res   = (sum + (u64_t'(1) << (shift - 1))) >> shift;
    if (res > 64'd2147483647) return 32'sh7FFFFFFF;
    return int'(res);
  endfunction

  function void set_terms(int unsigned v);
    term_cfg = v & 31;
  endfunction

  function void bump(int unsigned a, int c, int v);
    force_mem[a * 3 + c] = sat(longint'(force_mem[a * 3 + c]) + longint'(v));
  endfunction

  function void note_input(accum_cmd_t t);
    int unsigned ch;
    int unsigned nt;
    int          ad;
    int          gs;
    int          gv;
    int          dv[3];
    force_rd_t   rd;
    dv[0] = t.dx;
    dv[1] = t.dy;
    dv[2] = t.dz;
    case (t.kind)
      rpfa_pkg::KIND_COEF: begin
        if (t.tix < 48) begin
          alpha_tbl[t.tix]  = t.sv;
          weight_tbl[t.tix] = t.dx;
        end
      end
      rpfa_pkg::KIND_GRAD: begin
        if (t.tix < 16) grad_tbl[t.atom * 16 + t.tix] = t.sv;
      end
      rpfa_pkg::KIND_PAIR: begin
        if (t.amol == t.nmol) ch = rpfa_pkg::CH_SAME_MOL;
        else if (t.pcol == t.ncol) ch = rpfa_pkg::CH_PARTNER;
        else ch = rpfa_pkg::CH_OTHER;
        nt = (term_cfg > 16) ? 16 : term_cfg;
        for (int i = 0; i < nt; i++) begin
          ad = qmul(alpha_tbl[ch * 16 + i], t.sv);
          gs = qmul(qmul(weight_tbl[ch * 16 + i], qexp(ad)), sat(longint'(ad) + 65536));
          gs = qmul(qmul(gs, 32768), grad_tbl[t.atom * 16 + i]);
          for (int c = 0; c < 3; c++) begin
            gv = qmul(gs, dv[c]);
            bump(t.atom, c, sat(-longint'(gv)));
            bump(t.nb, c, gv);
          end
        end
      end
      default: begin
        rd.atom = t.atom;
        rd.fx   = force_mem[t.atom * 3];
        rd.fy   = force_mem[t.atom * 3 + 1];
        rd.fz   = force_mem[t.atom * 3 + 2];
        for (int c = 0; c < 3; c++) force_mem[t.atom * 3 + c] = 0;
        due_q.push_back(rd);
      end
    endcase
  endfunction

  function void check_result(logic [111:0] d);
    force_rd_t want;
    if (due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: tdata=%h", d);
      return;
    end
    want = due_q.pop_front();
    if (d[9:0] !== want.atom || d[41:10] !== want.fx || d[73:42] !== want.fy ||
        d[105:74] !== want.fz) begin
      mismatches++;
      if (mismatches <= 10)
        $display("force mismatch: exp atom=%0d f=(%h %h %h) got atom=%0d f=(%h %h %h)",
                 want.atom, want.fx, want.fy, want.fz,
                 d[9:0], d[41:10], d[73:42], d[105:74]);
    end
  endfunction

  function int pending();
    return due_q.size();
  endfunction
endclass

module tb_radial_pair_force_accumulator_core;

  // generous bound: clearing pass, preload, 1450 random commands at up to 16 terms, stalls
  localparam longint CYCLE_LIMIT = 8000000;
  // a pair at 16 terms keeps the back end busy longest; up to two more wait in
  // the queue behind it
  localparam int     SETTLE_CYCLES = 4000;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [4:0]   cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;

  force_scoreboard sb;
  accum_cmd_t      cur_cmd;      // command on the bus, noted on acceptance
  logic [9:0]      atom_pool[8]; // atoms whose gradients are all loaded
  bit              tx_burst;     // sender without gaps
  bit              rx_burst;     // receiver without stalls
  int              rx_hold;      // long receiver hold-off, in cycles
  int              rx_stall;
  longint          cycle_cnt;

  radial_pair_force_accumulator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** radial_pair_force_accumulator_core: FAILED **");
      $finish;
    end
  end

  // Result side: check every accepted transaction, then draw the next stall
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
      rx_stall = rx_burst ? 0 : $urandom_range(0, 19);
    end
  end

  // Receiver: ready driven on the falling edge; long hold-offs counted here
  initial begin
    rx_stall = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed($urandom_range(0, 524288)) - 32'sd262144; // +-4.0
      4, 5:       return $signed($urandom_range(0, 13107)) - 32'sd6553;    // +-0.1
      6, 7:       return $urandom();
      default: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh7FFFFFFF;
          1:       return 32'sh80000000;
          2:       return rpfa_pkg::Q_ONE;
          3:       return -rpfa_pkg::Q_ONE;
          default: return 32'sd0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [9:0] pick_atom();
    if ($urandom_range(0, 4) != 0) return atom_pool[$urandom_range(0, 7)];
    return $urandom_range(0, 1023);
  endfunction

  // Send one command; returns on the falling edge after acceptance
  task automatic push_cmd(input accum_cmd_t t);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_cmd        = t;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= t.kind;
    s_axis_tdata  <= {2'b00, t.tix, t.dz, t.dy, t.dx, t.sv, t.ncol, t.pcol,
                      t.nmol, t.amol, t.nb, t.atom};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cur_cmd);
    @(negedge clk_i);
  endtask

  // Quiet point: all reads returned, and the back end given time to finish a pair
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_terms(input int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[4:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_terms(v);
  endtask

  function automatic accum_cmd_t blank_cmd(input logic [1:0] k);
    accum_cmd_t t;
    t.kind = k;
    t.atom = $urandom_range(0, 1023);
    t.nb   = $urandom_range(0, 1023);
    t.amol = $urandom_range(0, 1023);
    t.nmol = $urandom_range(0, 1023);
    t.pcol = $urandom_range(0, 255);
    t.ncol = $urandom_range(0, 255);
    t.sv   = rand_q();
    t.dx   = rand_q();
    t.dy   = rand_q();
    t.dz   = rand_q();
    t.tix  = $urandom_range(0, 63);
    return t;
  endfunction

  // Pair with controlled channel: 0 same molecule, 1 other, 2 color partner
  function automatic accum_cmd_t pair_cmd(input logic [9:0] a, input logic [9:0] n,
                                          input logic [1:0] ch);
    accum_cmd_t t;
    t      = blank_cmd(rpfa_pkg::KIND_PAIR);
    t.atom = a;
    t.nb   = n;
    if (ch == rpfa_pkg::CH_SAME_MOL) t.nmol = t.amol;
    else begin
      if (t.nmol == t.amol) t.nmol = ~t.amol;
      if (ch == rpfa_pkg::CH_PARTNER) t.ncol = t.pcol;
      else if (t.ncol == t.pcol) t.ncol = ~t.pcol;
    end
    return t;
  endfunction

  function automatic accum_cmd_t read_cmd(input logic [9:0] a);
    accum_cmd_t t;
    t      = blank_cmd(rpfa_pkg::KIND_READ);
    t.atom = a;
    return t;
  endfunction

  function automatic accum_cmd_t random_cmd();
    accum_cmd_t t;
    int         sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      t = blank_cmd(rpfa_pkg::KIND_COEF);
      if ($urandom_range(0, 3) != 0) t.tix = $urandom_range(0, 47);
    end else if (sel < 16) begin
      t = blank_cmd(rpfa_pkg::KIND_GRAD);
      if ($urandom_range(0, 3) != 0) t.tix = $urandom_range(0, 15);
      if ($urandom_range(0, 1) != 0) t.atom = atom_pool[$urandom_range(0, 7)];
    end else if (sel < 60) begin
      t = pair_cmd(atom_pool[$urandom_range(0, 7)], pick_atom(), $urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) t = blank_cmd(rpfa_pkg::KIND_PAIR);
      t.atom = atom_pool[$urandom_range(0, 7)];
    end else begin
      t = read_cmd(pick_atom());
    end
    return t;
  endfunction

  initial begin
    accum_cmd_t  t;
    int unsigned phase_terms[6] = '{1, 3, 0, 16, 7, 2};
    int          phase_items[6] = '{350, 330, 180, 90, 220, 280};

    sb            = new();
    atom_pool     = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd500, 10'd1021, 10'd1022, 10'd1023};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = rpfa_pkg::KIND_COEF;
    m_axis_tready = 1'b0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    rx_hold       = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // term count above the table size acts as the full 16
    write_terms(31);

    // Fill every coefficient and the gradients of the atom pool
    tx_burst = 1'b1;
    for (int i = 0; i < 48; i++) begin
      t     = blank_cmd(rpfa_pkg::KIND_COEF);
      t.tix = i;
      push_cmd(t);
    end
    foreach (atom_pool[p]) begin
      for (int i = 0; i < 16; i++) begin
        t      = blank_cmd(rpfa_pkg::KIND_GRAD);
        t.atom = atom_pool[p];
        t.tix  = i;
        push_cmd(t);
      end
    end
    tx_burst = 1'b0;

    // Directed: all channels, same atom twice, extremes, ignored loads, edge reads
    push_cmd(pair_cmd(10'd0, 10'd1, rpfa_pkg::CH_SAME_MOL));
    push_cmd(pair_cmd(10'd2, 10'd3, rpfa_pkg::CH_OTHER));
    push_cmd(pair_cmd(10'd1023, 10'd0, rpfa_pkg::CH_PARTNER));
    push_cmd(pair_cmd(10'd500, 10'd500, rpfa_pkg::CH_OTHER));
    t    = pair_cmd(10'd1021, 10'd1022, rpfa_pkg::CH_SAME_MOL);
    t.sv = 32'sh7FFFFFFF; t.dx = 32'sh7FFFFFFF; t.dy = 32'sh80000000; t.dz = 32'sd0;
    push_cmd(t);
    t = blank_cmd(rpfa_pkg::KIND_COEF); t.tix = 6'd48; push_cmd(t);
    t = blank_cmd(rpfa_pkg::KIND_COEF); t.tix = 6'd63; push_cmd(t);
    t = blank_cmd(rpfa_pkg::KIND_GRAD); t.tix = 6'd16; push_cmd(t);
    t = blank_cmd(rpfa_pkg::KIND_GRAD); t.tix = 6'd63; push_cmd(t);
    t = blank_cmd(rpfa_pkg::KIND_COEF); t.tix = 6'd47; t.sv = 32'sh80000000;
    t.dx = 32'sh7FFFFFFF;
    push_cmd(t);
    t = blank_cmd(rpfa_pkg::KIND_GRAD); t.atom = 10'd1023; t.tix = 6'd15;
    t.sv = 32'sh7FFFFFFF;
    push_cmd(t);
    push_cmd(pair_cmd(10'd1023, 10'd1023, rpfa_pkg::CH_PARTNER));
    push_cmd(read_cmd(10'd0));
    push_cmd(read_cmd(10'd1));
    push_cmd(read_cmd(10'd1023));
    push_cmd(read_cmd(10'd777));
    push_cmd(read_cmd(10'd1022));
    push_cmd(read_cmd(10'd500));
    push_cmd(read_cmd(10'd0));

    // Random phases, each with its own term count; quiet point before each write
    foreach (phase_terms[p]) begin
      drain();
      write_terms(phase_terms[p]);
      tx_burst = (p == 2) || (p == 4);
      rx_burst = (p == 1);
      if (p == 2) rx_hold = 3000;  // results back up and stall the input
      for (int n = 0; n < phase_items[p]; n++) push_cmd(random_cmd());
    end

    // Collect what is left on the pool atoms
    foreach (atom_pool[p]) push_cmd(read_cmd(atom_pool[p]));
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("** radial_pair_force_accumulator_core: PASSED **");
    else
      $display("** radial_pair_force_accumulator_core: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rpfa_pkg.sv
rtl/core/rpfa_ram.sv
rtl/core/rpfa_front.sv
rtl/core/rpfa_queue.sv
rtl/core/rpfa_back.sv
rtl/core/radial_pair_force_accumulator_core.sv
verif/tb_radial_pair_force_accumulator_core.sv
